[design/affine_warp_bilinear_core_macros.svh]
// assertion helpers for the affine warp core
`ifndef AFFINE_WARP_BILINEAR_CORE_MACROS_SVH
`define AFFINE_WARP_BILINEAR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define AWB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define AWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[design/awb_pkg.sv]
package awb_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int PIXEL_BITS = 16;
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int FRAC_FINE  = 26;
  localparam int FRAC_KEEP  = 14;
  localparam int SHEAR_FRAC = 12;
  localparam int SHIFT_POS  = 18;

  localparam int CFG_BITS   = 17;
  localparam int IDX_BITS   = 3;

  localparam int MUL_A_BITS = 17;
  localparam int MUL_B_BITS = 30;
  localparam int ACC_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int INT_BITS   = ACC_BITS - FRAC_FINE;
  localparam int COORD_BITS = 26;
  localparam int WT_BITS    = 2 * FRAC_KEEP + 1;

  localparam logic [FRAC_KEEP:0] ONE_Q = (FRAC_KEEP + 1)'(1) << FRAC_KEEP;
  localparam logic signed [MUL_A_BITS-1:0] SHEAR_ONE = MUL_A_BITS'(1) << SHEAR_FRAC;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_COS       = 3'd2,
    REG_SIN       = 3'd3,
    REG_SHEAR_COL = 3'd4,
    REG_SHEAR_ROW = 3'd5,
    REG_SHIFT_COL = 3'd6,
    REG_SHIFT_ROW = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RC0,
    ST_RC1,
    ST_RR0,
    ST_RR1,
    ST_TC0,
    ST_TC1,
    ST_TR0,
    ST_TR1,
    ST_CHK,
    ST_WT,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

[design/awb_ram.sv]
module awb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/affine_warp_bilinear_core.sv]
// Affine warp with bilinear interpolation over one 128x128 plane of 16-bit pixels held in an
// internal single-port store. A write item (cmd 0) stores pixel_in at (row, col) and gives no
// result. A compute item (cmd 1) gives one result: the output position is rotated about the
// image centre, sheared, translated and floored, and the four neighbours are blended with
// truncation; out-of-range source points give pixel 0 with in_range low. One shared 17x30
// multiplier does eight transform steps and two steps per neighbour, and the four neighbours
// come one at a time from the single store port. The finished result sits in an output
// register, so a new item is taken while it waits. The user must write the configuration
// registers through cfg_we/cfg_index/cfg_wdata only while the block is idle; the block itself
// does not enforce this. Reading a store entry that was never written gives an undefined pixel.
`include "affine_warp_bilinear_core_macros.svh"

module affine_warp_bilinear_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [awb_pkg::ROW_BITS-1:0]        in_row,
  input  logic [awb_pkg::COL_BITS-1:0]        in_col,
  input  logic [awb_pkg::PIXEL_BITS-1:0]      in_pixel_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [awb_pkg::PIXEL_BITS-1:0]      out_pixel_out,
  output logic                                out_in_range,
  input  logic                                cfg_we,
  input  logic [awb_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [awb_pkg::CFG_BITS-1:0]        cfg_wdata
);

  // configuration
  logic [7:0]         width_r, height_r;
  logic signed [15:0] cos_r, sin_r, shear_col_r, shear_row_r;
  logic signed [16:0] shift_col_r, shift_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 8'(awb_pkg::MAX_WIDTH);
      height_r    <= 8'(awb_pkg::MAX_HEIGHT);
      cos_r       <= 16'sd16384;
      sin_r       <= '0;
      shear_col_r <= '0;
      shear_row_r <= '0;
      shift_col_r <= '0;
      shift_row_r <= '0;
    end else if (cfg_we) begin
      case (awb_pkg::reg_idx_t'(cfg_index))
        awb_pkg::REG_WIDTH:     width_r     <= cfg_wdata[7:0];
        awb_pkg::REG_HEIGHT:    height_r    <= cfg_wdata[7:0];
        awb_pkg::REG_COS:       cos_r       <= cfg_wdata[15:0];
        awb_pkg::REG_SIN:       sin_r       <= cfg_wdata[15:0];
        awb_pkg::REG_SHEAR_COL: shear_col_r <= cfg_wdata[15:0];
        awb_pkg::REG_SHEAR_ROW: shear_row_r <= cfg_wdata[15:0];
        awb_pkg::REG_SHIFT_COL: shift_col_r <= cfg_wdata;
        awb_pkg::REG_SHIFT_ROW: shift_row_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped size, centre and last valid corner
  logic [7:0] w_clamp, h_clamp, w_lim, h_lim;
  logic [6:0] wc, hc;

  always_comb begin
    if (width_r < 8'd2) begin
      w_clamp = 8'd2;
    end else if (width_r > 8'(awb_pkg::MAX_WIDTH)) begin
      w_clamp = 8'(awb_pkg::MAX_WIDTH);
    end else begin
      w_clamp = width_r;
    end
    if (height_r < 8'd2) begin
      h_clamp = 8'd2;
    end else if (height_r > 8'(awb_pkg::MAX_HEIGHT)) begin
      h_clamp = 8'(awb_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = height_r;
    end
    wc    = w_clamp[7:1];
    hc    = h_clamp[7:1];
    w_lim = w_clamp - 8'd2;
    h_lim = h_clamp - 8'd2;
  end

  // sequencer registers
  awb_pkg::state_t state_r, state_nxt;
  logic [1:0]  nb_r, nb_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [awb_pkg::PIXEL_BITS-1:0] out_pixel_r, out_pixel_nxt;
  logic        out_range_r, out_range_nxt;
  logic        range_r, range_nxt;

  logic signed [7:0] dr_r, dr_nxt, dc_r, dc_nxt;
  logic signed [awb_pkg::COORD_BITS-1:0] rc_r, rc_nxt, rr_r, rr_nxt;
  logic signed [awb_pkg::ACC_BITS-1:0]   acc_r, acc_nxt, tc_r, tc_nxt;
  logic [6:0] fr_r, fr_nxt, fc_r, fc_nxt;
  logic [awb_pkg::FRAC_KEEP-1:0] ur_r, ur_nxt, uc_r, uc_nxt;
  logic [awb_pkg::WT_BITS-1:0] wt_r, wt_nxt;

  // shared multiply-add unit
  logic signed [awb_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [awb_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [awb_pkg::ACC_BITS-1:0]   mul_p, addend;

  assign mul_p = mul_a * mul_b;

  // store
  logic ram_we;
  logic [awb_pkg::ADDR_BITS-1:0] ram_addr;
  logic [awb_pkg::PIXEL_BITS-1:0] ram_rdata;
  logic [6:0] rd_row, rd_col;

  awb_ram #(
    .WIDTH (awb_pkg::PIXEL_BITS),
    .DEPTH (awb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_pixel_in),
    .rdata (ram_rdata)
  );

  // floored source point and bounds
  logic signed [awb_pkg::INT_BITS-1:0] fc_full, fr_full;
  logic src_ok;
  logic [awb_pkg::FRAC_KEEP:0] col_wt, row_wt;

  always_comb begin
    fc_full = tc_r[awb_pkg::ACC_BITS-1:awb_pkg::FRAC_FINE];
    fr_full = acc_r[awb_pkg::ACC_BITS-1:awb_pkg::FRAC_FINE];
    src_ok  = !fc_full[awb_pkg::INT_BITS-1] && !fr_full[awb_pkg::INT_BITS-1]
              && (fc_full[awb_pkg::INT_BITS-2:0] <= (awb_pkg::INT_BITS-1)'(w_lim))
              && (fr_full[awb_pkg::INT_BITS-2:0] <= (awb_pkg::INT_BITS-1)'(h_lim));
    col_wt  = nb_r[0] ? {1'b0, uc_r} : awb_pkg::ONE_Q - {1'b0, uc_r};
    row_wt  = nb_r[1] ? {1'b0, ur_r} : awb_pkg::ONE_Q - {1'b0, ur_r};
    rd_row  = fr_r + 7'(nb_r[1]);
    rd_col  = fc_r + 7'(nb_r[0]);
  end

  assign in_ready = (state_r == awb_pkg::ST_IDLE);
  assign ram_we   = in_ready && in_valid && (in_cmd == awb_pkg::CMD_WRITE);
  assign ram_addr = ram_we ? {in_row, in_col} : {rd_row, rd_col};

  always_comb begin
    state_nxt     = state_r;
    nb_nxt        = nb_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_range_nxt = out_range_r;
    range_nxt     = range_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    rc_nxt        = rc_r;
    rr_nxt        = rr_r;
    tc_nxt        = tc_r;
    acc_nxt       = acc_r;
    fr_nxt        = fr_r;
    fc_nxt        = fc_r;
    ur_nxt        = ur_r;
    uc_nxt        = uc_r;
    wt_nxt        = wt_r;
    mul_a         = '0;
    mul_b         = '0;
    addend        = acc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      awb_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == awb_pkg::CMD_COMPUTE) begin
          dr_nxt    = $signed({1'b0, in_row}) - $signed({1'b0, hc});
          dc_nxt    = $signed({1'b0, in_col}) - $signed({1'b0, wc});
          nb_nxt    = '0;
          state_nxt = awb_pkg::ST_RC0;
        end
      end
      // rotated column
      awb_pkg::ST_RC0: begin
        mul_a     = 17'(sin_r);
        mul_b     = 30'(dr_r);
        addend    = {26'd0, wc, 14'd0};
        acc_nxt   = mul_p + addend;
        state_nxt = awb_pkg::ST_RC1;
      end
      awb_pkg::ST_RC1: begin
        mul_a     = 17'(cos_r);
        mul_b     = 30'(dc_r);
        acc_nxt   = mul_p + addend;
        rc_nxt    = acc_nxt[awb_pkg::COORD_BITS-1:0];
        state_nxt = awb_pkg::ST_RR0;
      end
      // rotated row
      awb_pkg::ST_RR0: begin
        mul_a     = 17'(cos_r);
        mul_b     = 30'(dr_r);
        addend    = {26'd0, hc, 14'd0};
        acc_nxt   = mul_p + addend;
        state_nxt = awb_pkg::ST_RR1;
      end
      awb_pkg::ST_RR1: begin
        mul_a     = -17'(sin_r);
        mul_b     = 30'(dc_r);
        acc_nxt   = mul_p + addend;
        rr_nxt    = acc_nxt[awb_pkg::COORD_BITS-1:0];
        state_nxt = awb_pkg::ST_TC0;
      end
      // sheared and translated column, Q26
      awb_pkg::ST_TC0: begin
        mul_a     = 17'(shear_col_r);
        mul_b     = 30'(rr_r);
        addend    = 47'(shift_col_r) <<< awb_pkg::SHIFT_POS;
        acc_nxt   = mul_p + addend;
        state_nxt = awb_pkg::ST_TC1;
      end
      awb_pkg::ST_TC1: begin
        mul_a     = awb_pkg::SHEAR_ONE;
        mul_b     = 30'(rc_r);
        acc_nxt   = mul_p + addend;
        tc_nxt    = acc_nxt;
        state_nxt = awb_pkg::ST_TR0;
      end
      // sheared and translated row, Q26
      awb_pkg::ST_TR0: begin
        mul_a     = 17'(shear_row_r);
        mul_b     = 30'(rc_r);
        addend    = 47'(shift_row_r) <<< awb_pkg::SHIFT_POS;
        acc_nxt   = mul_p + addend;
        state_nxt = awb_pkg::ST_TR1;
      end
      awb_pkg::ST_TR1: begin
        mul_a     = awb_pkg::SHEAR_ONE;
        mul_b     = 30'(rr_r);
        acc_nxt   = mul_p + addend;
        state_nxt = awb_pkg::ST_CHK;
      end
      awb_pkg::ST_CHK: begin
        range_nxt = src_ok;
        fc_nxt    = fc_full[6:0];
        fr_nxt    = fr_full[6:0];
        uc_nxt    = tc_r[awb_pkg::FRAC_FINE-1 -: awb_pkg::FRAC_KEEP];
        ur_nxt    = acc_r[awb_pkg::FRAC_FINE-1 -: awb_pkg::FRAC_KEEP];
        state_nxt = src_ok ? awb_pkg::ST_WT : awb_pkg::ST_DONE;
      end
      // neighbour weight while its read is in flight
      awb_pkg::ST_WT: begin
        mul_a     = 17'(col_wt);
        mul_b     = 30'(row_wt);
        wt_nxt    = mul_p[awb_pkg::WT_BITS-1:0];
        state_nxt = awb_pkg::ST_ACC;
      end
      awb_pkg::ST_ACC: begin
        mul_a     = 17'(ram_rdata);
        mul_b     = 30'(wt_r);
        addend    = (nb_r == 2'd0) ? '0 : acc_r;
        acc_nxt   = mul_p + addend;
        nb_nxt    = nb_r + 2'd1;
        state_nxt = (nb_r == 2'd3) ? awb_pkg::ST_DONE : awb_pkg::ST_WT;
      end
      awb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_range_nxt = range_r;
          out_pixel_nxt = range_r ? acc_r[2*awb_pkg::FRAC_KEEP +: awb_pkg::PIXEL_BITS] : '0;
          state_nxt     = awb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = awb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= awb_pkg::ST_IDLE;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    out_range_r <= out_range_nxt;
    range_r     <= range_nxt;
    dr_r        <= dr_nxt;
    dc_r        <= dc_nxt;
    rc_r        <= rc_nxt;
    rr_r        <= rr_nxt;
    tc_r        <= tc_nxt;
    acc_r       <= acc_nxt;
    fr_r        <= fr_nxt;
    fc_r        <= fc_nxt;
    ur_r        <= ur_nxt;
    uc_r        <= uc_nxt;
    wt_r        <= wt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_in_range  = out_range_r;

  `AWB_ASSERT_NOW(a_zero_when_out_of_range, out_valid && !out_in_range, out_pixel_out == '0)
  `AWB_ASSERT_NEXT(a_busy_after_compute, in_valid && in_ready && in_cmd == awb_pkg::CMD_COMPUTE, !in_ready)
  `AWB_ASSERT_NOW(a_nb_clear_at_check, state_r == awb_pkg::ST_CHK, nb_r == 2'd0)
  `AWB_ASSERT_NEXT(a_result_after_done, state_r == awb_pkg::ST_DONE && (!out_valid_r || out_ready), out_valid_r && state_r == awb_pkg::ST_IDLE)

endmodule
